### hdl/fbde_pkg.sv
// Shared constants, command codes and controller/datapath interface types
// for the monochrome framebuffer draw engine. No dependencies.
package fbde_pkg;

  localparam int unsigned SCREEN_WIDTH  = 128;
  localparam int unsigned SCREEN_HEIGHT = 64;
  localparam int unsigned PAGES         = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned STORE_BYTES   = SCREEN_WIDTH * PAGES;
  localparam int unsigned ADDR_W        = $clog2(STORE_BYTES);

  localparam logic [3:0] OP_CLEAR      = 4'd0;
  localparam logic [3:0] OP_SET        = 4'd1;
  localparam logic [3:0] OP_READ       = 4'd2;
  localparam logic [3:0] OP_HSPAN      = 4'd3;
  localparam logic [3:0] OP_VSPAN      = 4'd4;
  localparam logic [3:0] OP_LINE       = 4'd5;
  localparam logic [3:0] OP_RECT       = 4'd6;
  localparam logic [3:0] OP_FILLRECT   = 4'd7;
  localparam logic [3:0] OP_CIRCLE     = 4'd8;
  localparam logic [3:0] OP_FILLCIRCLE = 4'd9;

  localparam logic [1:0] INK_WHITE  = 2'd0;
  localparam logic [1:0] INK_BLACK  = 2'd1;
  localparam logic [1:0] INK_INVERT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the command fields
    logic start;     // initialize the pixel walker
    logic clr_step;  // write one byte of a fill sweep
    logic clr_zero;  // the sweep writes zeros (reset clearing pass)
    logic rd_issue;  // read the byte of a pixel read
    logic rd_take;   // capture the read pixel bit
    logic eval;      // register the current candidate pixel
    logic write;     // write back the modified byte
    logic advance;   // step the walker to the next candidate
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [3:0] op;
    logic       empty;     // the shape covers no pixel at all
    logic       clr_last;  // sweep is at the final byte
    logic       hit;       // registered candidate is to be plotted
    logic       last;      // current candidate is the final one
    logic       result;
  } sts_t;

endpackage

### hdl/fbde_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module fbde_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fbde_ctrl.sv
// Sequencing state machine of the draw engine and the result register.
// Depends on fbde_pkg.
module fbde_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           pixel_on_o,
  output fbde_pkg::ctl_t ctl_o,
  input  fbde_pkg::sts_t sts_i
);
  import fbde_pkg::*;

  typedef enum logic [9:0] {
    S_INIT  = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_START = 10'b00_0000_0100,
    S_CLR   = 10'b00_0000_1000,
    S_RD1   = 10'b00_0001_0000,
    S_RD2   = 10'b00_0010_0000,
    S_EVAL  = 10'b00_0100_0000,
    S_CHK   = 10'b00_1000_0000,
    S_WR    = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   pixel_on_q, pixel_on_d;
  logic   out_load;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    out_load = 1'b0;
    case (state_q)
      S_INIT: begin
        ctl_o.clr_step = 1'b1;
        ctl_o.clr_zero = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d = S_START;
        end
      end
      S_START: begin
        ctl_o.start = 1'b1;
        case (sts_i.op)
          OP_CLEAR: state_d = S_CLR;
          OP_READ:  state_d = S_RD1;
          OP_SET, OP_HSPAN, OP_VSPAN, OP_LINE, OP_RECT,
          OP_FILLRECT, OP_CIRCLE, OP_FILLCIRCLE: begin
            state_d = sts_i.empty ? S_FIN : S_EVAL;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_CLR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_FIN;
      end
      S_RD1: begin
        ctl_o.rd_issue = 1'b1;
        state_d = S_RD2;
      end
      S_RD2: begin
        ctl_o.rd_take = 1'b1;
        state_d = S_FIN;
      end
      S_EVAL: begin
        ctl_o.eval = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.hit) begin
          state_d = S_WR;
        end else begin
          ctl_o.advance = 1'b1;
          state_d = sts_i.last ? S_FIN : S_EVAL;
        end
      end
      S_WR: begin
        ctl_o.write   = 1'b1;
        ctl_o.advance = 1'b1;
        state_d = sts_i.last ? S_FIN : S_EVAL;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    pixel_on_d  = pixel_on_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      pixel_on_d  = sts_i.result;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
      pixel_on_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pixel_on_q  <= pixel_on_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pixel_on_o  = pixel_on_q;

endmodule

### hdl/fbde_dpath.sv
// Datapath of the draw engine: command registers, pixel walkers for all
// shapes, read-modify-write of the frame store. Depends on fbde_pkg, fbde_ram.
module fbde_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbde_pkg::ctl_t     ctl_i,
  input  logic [3:0]         opcode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] arg_x_i,
  input  logic signed [15:0] arg_y_i,
  input  logic [1:0]         ink_i,
  output fbde_pkg::sts_t     sts_o
);
  import fbde_pkg::*;

  function automatic logic on_screen(input logic [15:0] x, input logic [15:0] y);
    return !x[15] && !y[15] && (x < 16'(SCREEN_WIDTH)) && (y < 16'(SCREEN_HEIGHT));
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [15:0] x,
                                                 input logic [15:0] y);
    return ADDR_W'(x) + ADDR_W'(32'(y[15:3]) * SCREEN_WIDTH);
  endfunction

  // Command fields.
  logic [3:0]         op_q;
  logic [1:0]         ink_q;
  logic signed [15:0] px_q, py_q, ax_q, ay_q;

  // Walker state.
  logic [15:0]        cur_x_q, cur_x_d, cur_y_q, cur_y_d, cnt_q, cnt_d;
  logic [1:0]         seg_q, seg_d;
  logic signed [20:0] err_q, err_d;
  logic [16:0]        dxl_q, dxl_d, dyl_q, dyl_d;
  logic               sx_q, sx_d, sy_q, sy_d;
  logic [16:0]        ox_q, ox_d, oy_q, oy_d;
  logic [2:0]         k_q, k_d;
  logic [31:0]        rr_q;

  // Registered candidate.
  logic [15:0]        ev_x_q, ev_y_q;
  logic               shape_ok_q;
  logic [31:0]        dx2_q, dy2_q;

  logic [ADDR_W-1:0]  clr_q;
  logic               onscr_q, res_q;

  logic               circ, clr_last, raster_last, last, hit;
  logic [15:0]        cand_x, cand_y, rel_x, rel_y, mag_x, mag_y;
  logic               shape_ok;
  logic signed [16:0] diff_x, diff_y;
  logic [16:0]        dxl_n, dyl_n;
  logic signed [21:0] e2;
  logic               c1, c2;
  logic [16:0]        cy_n, cx_n;
  logic signed [20:0] cerr_n;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [7:0]         ram_wdata, ram_rdata, mask;

  assign circ = (op_q == OP_CIRCLE) && (ax_q > 16'sd0);
  assign clr_last = (clr_q == ADDR_W'(STORE_BYTES - 1));
  assign raster_last = (cur_x_q == 16'(SCREEN_WIDTH - 1)) &&
                       (cur_y_q == 16'(SCREEN_HEIGHT - 1));

  // Line setup.
  always_comb begin
    diff_x = 17'(ax_q) - 17'(px_q);
    diff_y = 17'(ay_q) - 17'(py_q);
    dxl_n  = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
    dyl_n  = diff_y[16] ? 17'(-diff_y) : 17'(diff_y);
  end

  // Line step decision.
  always_comb begin
    e2 = 22'(err_q) <<< 1;
    c1 = e2 >= -22'(signed'({1'b0, dyl_q}));
    c2 = e2 <= 22'(signed'({1'b0, dxl_q}));
  end

  // Midpoint circle step.
  always_comb begin
    cy_n = oy_q + 17'd1;
    cx_n = err_q[20] ? ox_q : ox_q - 17'd1;
    if (err_q[20]) begin
      cerr_n = err_q + 21'(signed'({1'b0, cy_n, 1'b1}));
    end else begin
      cerr_n = err_q + (21'(signed'({1'b0, cy_n})) - 21'(signed'({1'b0, cx_n}))) * 21'sd2
               + 21'sd1;
    end
  end

  // Current candidate pixel.
  always_comb begin
    cand_x = cur_x_q;
    cand_y = cur_y_q;
    if (circ) begin
      case (k_q)
        3'd0: begin cand_x = px_q + ox_q[15:0]; cand_y = py_q + oy_q[15:0]; end
        3'd1: begin cand_x = px_q + oy_q[15:0]; cand_y = py_q + ox_q[15:0]; end
        3'd2: begin cand_x = px_q - oy_q[15:0]; cand_y = py_q + ox_q[15:0]; end
        3'd3: begin cand_x = px_q - ox_q[15:0]; cand_y = py_q + oy_q[15:0]; end
        3'd4: begin cand_x = px_q - ox_q[15:0]; cand_y = py_q - oy_q[15:0]; end
        3'd5: begin cand_x = px_q - oy_q[15:0]; cand_y = py_q - ox_q[15:0]; end
        3'd6: begin cand_x = px_q + oy_q[15:0]; cand_y = py_q - ox_q[15:0]; end
        default: begin cand_x = px_q + ox_q[15:0]; cand_y = py_q - oy_q[15:0]; end
      endcase
    end
  end

  // Shape membership for the filled shapes.
  always_comb begin
    rel_x = cand_x - px_q;
    rel_y = cand_y - py_q;
    mag_x = rel_x[15] ? -rel_x : rel_x;
    mag_y = rel_y[15] ? -rel_y : rel_y;
    case (op_q)
      OP_FILLRECT: shape_ok = (rel_x < $unsigned(ax_q)) && (rel_y < $unsigned(ay_q));
      OP_FILLCIRCLE: begin
        shape_ok = (signed'(rel_x) <= ax_q) && (signed'(rel_x) >= -ax_q) &&
                   (signed'(rel_y) <= ax_q) && (signed'(rel_y) >= -ax_q);
      end
      default: shape_ok = 1'b1;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_SET:              last = 1'b1;
      OP_HSPAN, OP_VSPAN:  last = (cnt_q == 16'd1);
      OP_RECT:             last = (cnt_q == 16'd1) && (seg_q == 2'd3);
      OP_LINE:             last = (cur_x_q == ax_q) && (cur_y_q == ay_q);
      OP_CIRCLE:           last = circ ? ((k_q == 3'd7) && (cx_n < cy_n)) : 1'b1;
      OP_FILLRECT, OP_FILLCIRCLE: last = raster_last;
      default:             last = 1'b1;
    endcase
  end

  assign hit = on_screen(ev_x_q, ev_y_q) && shape_ok_q && (ink_q != 2'd3) &&
               ((op_q != OP_FILLCIRCLE) || ((33'(dx2_q) + 33'(dy2_q)) <= 33'(rr_q)));

  // Walker next state.
  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    cnt_d   = cnt_q;
    seg_d   = seg_q;
    err_d   = err_q;
    dxl_d   = dxl_q;
    dyl_d   = dyl_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    k_d     = k_q;
    if (ctl_i.start) begin
      cur_x_d = px_q;
      cur_y_d = py_q;
      seg_d   = 2'd0;
      k_d     = 3'd0;
      ox_d    = {1'b0, ax_q};
      oy_d    = 17'd0;
      dxl_d   = dxl_n;
      dyl_d   = dyl_n;
      sx_d    = !(px_q < ax_q);
      sy_d    = !(py_q < ay_q);
      cnt_d   = (op_q == OP_VSPAN) ? ay_q : ax_q;
      case (op_q)
        OP_LINE: err_d = 21'(signed'({1'b0, dxl_n})) - 21'(signed'({1'b0, dyl_n}));
        OP_FILLRECT, OP_FILLCIRCLE: begin
          cur_x_d = 16'd0;
          cur_y_d = 16'd0;
        end
        default: err_d = 21'sd1 - 21'(ax_q);
      endcase
    end else if (ctl_i.advance) begin
      case (op_q)
        OP_HSPAN: begin
          cur_x_d = cur_x_q + 16'd1;
          cnt_d   = cnt_q - 16'd1;
        end
        OP_VSPAN: begin
          cur_y_d = cur_y_q + 16'd1;
          cnt_d   = cnt_q - 16'd1;
        end
        OP_RECT: begin
          if (cnt_q == 16'd1) begin
            seg_d = seg_q + 2'd1;
            case (seg_q)
              2'd0: begin cur_x_d = px_q; cur_y_d = py_q + ay_q - 16'd1; cnt_d = ax_q; end
              2'd1: begin cur_x_d = px_q; cur_y_d = py_q; cnt_d = ay_q; end
              default: begin
                cur_x_d = px_q + ax_q - 16'd1;
                cur_y_d = py_q;
                cnt_d   = ay_q;
              end
            endcase
          end else begin
            cnt_d = cnt_q - 16'd1;
            if (seg_q[1]) cur_y_d = cur_y_q + 16'd1;
            else          cur_x_d = cur_x_q + 16'd1;
          end
        end
        OP_LINE: begin
          err_d = err_q + (c1 ? -21'(signed'({1'b0, dyl_q})) : 21'sd0)
                        + (c2 ?  21'(signed'({1'b0, dxl_q})) : 21'sd0);
          if (c1) cur_x_d = sx_q ? cur_x_q - 16'd1 : cur_x_q + 16'd1;
          if (c2) cur_y_d = sy_q ? cur_y_q - 16'd1 : cur_y_q + 16'd1;
        end
        OP_CIRCLE: begin
          if (k_q != 3'd7) begin
            k_d = k_q + 3'd1;
          end else begin
            k_d   = 3'd0;
            oy_d  = cy_n;
            ox_d  = cx_n;
            err_d = cerr_n;
          end
        end
        OP_FILLRECT, OP_FILLCIRCLE: begin
          if (cur_x_q == 16'(SCREEN_WIDTH - 1)) begin
            cur_x_d = 16'd0;
            cur_y_d = cur_y_q + 16'd1;
          end else begin
            cur_x_d = cur_x_q + 16'd1;
          end
        end
        default: cnt_d = cnt_q;
      endcase
    end
  end

  // Frame store port selection.
  always_comb begin
    mask      = 8'd1 << ev_y_q[2:0];
    ram_we    = 1'b0;
    ram_wdata = 8'h00;
    ram_addr  = pix_addr(ev_x_q, ev_y_q);
    if (ctl_i.clr_step) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = (!ctl_i.clr_zero && (ink_q == INK_WHITE)) ? 8'hFF : 8'h00;
    end else if (ctl_i.write) begin
      ram_we = 1'b1;
      case (ink_q)
        INK_WHITE:  ram_wdata = ram_rdata | mask;
        INK_BLACK:  ram_wdata = ram_rdata & ~mask;
        INK_INVERT: ram_wdata = ram_rdata ^ mask;
        default:    ram_wdata = ram_rdata;
      endcase
    end else if (ctl_i.rd_issue) begin
      ram_addr = pix_addr(px_q, py_q);
    end
  end

  fbde_ram #(
    .DATA_W (8),
    .DEPTH  (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= opcode_i;
      ink_q <= ink_i;
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      ax_q  <= arg_x_i;
      ay_q  <= arg_y_i;
    end
    if (ctl_i.start) begin
      rr_q <= 32'(ax_q[15:0]) * 32'(ax_q[15:0]);
    end
    if (ctl_i.eval) begin
      ev_x_q     <= cand_x;
      ev_y_q     <= cand_y;
      shape_ok_q <= shape_ok;
      dx2_q      <= 32'(mag_x) * 32'(mag_x);
      dy2_q      <= 32'(mag_y) * 32'(mag_y);
    end
    if (ctl_i.rd_issue) begin
      onscr_q <= on_screen(px_q, py_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      cnt_q   <= '0;
      seg_q   <= '0;
      err_q   <= '0;
      dxl_q   <= '0;
      dyl_q   <= '0;
      sx_q    <= 1'b0;
      sy_q    <= 1'b0;
      ox_q    <= '0;
      oy_q    <= '0;
      k_q     <= '0;
      clr_q   <= '0;
      res_q   <= 1'b0;
    end else begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      cnt_q   <= cnt_d;
      seg_q   <= seg_d;
      err_q   <= err_d;
      dxl_q   <= dxl_d;
      dyl_q   <= dyl_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      k_q     <= k_d;
      if (ctl_i.clr_step) begin
        clr_q <= clr_last ? '0 : clr_q + ADDR_W'(1);
      end
      if (ctl_i.start) begin
        res_q <= 1'b0;
      end else if (ctl_i.rd_take) begin
        res_q <= onscr_q & ram_rdata[py_q[2:0]];
      end
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.op       = op_q;
    sts_o.clr_last = clr_last;
    sts_o.hit      = hit;
    sts_o.last     = last;
    sts_o.result   = res_q;
    case (op_q)
      OP_HSPAN:                sts_o.empty = (ax_q <= 16'sd0);
      OP_VSPAN:                sts_o.empty = (ay_q <= 16'sd0);
      OP_RECT, OP_FILLRECT:    sts_o.empty = (ax_q <= 16'sd0) || (ay_q <= 16'sd0);
      OP_FILLCIRCLE:           sts_o.empty = (ax_q < 16'sd0);
      default:                 sts_o.empty = 1'b0;
    endcase
  end

endmodule

### hdl/mono_framebuffer_draw_engine_top.sv
// Top level of the monochrome framebuffer draw engine.
// Depends on fbde_pkg, fbde_ctrl, fbde_dpath (which holds fbde_ram).
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-----------------------------------------
//   in      | in_valid_i, in_stall_o | opcode_i, pos_x_i, pos_y_i, arg_x_i,
//           |                        | arg_y_i, ink_i
//   out     | out_valid_o, out_stall_i | pixel_on_o
//
// One command is worked on at a time. Every pixel goes through the single
// frame store port: a candidate is evaluated in S_EVAL and checked in S_CHK,
// and one that is plotted is then written in S_WR, so after the transfer a
// shape keeps input stalled for every visited pixel plus setup and result
// hand-off. Filled shapes scan the whole screen (8192 candidates), a clear
// sweeps 1024 bytes at one per cycle, a read passes S_RD1 and S_RD2, and a
// set passes S_WR only when it plots its pixel.
// After reset the store is cleared by a pass over all 1024 bytes, during
// which input stays stalled. The result sits in an output register, so the
// next command is accepted while an earlier result waits for a transfer.
module mono_framebuffer_draw_engine_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         opcode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] arg_x_i,
  input  logic signed [15:0] arg_y_i,
  input  logic [1:0]         ink_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               pixel_on_o
);
  import fbde_pkg::*;

  // Commands and status between the sequencer and the datapath.
  ctl_t ctl;
  sts_t sts;

  fbde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_on_o  (pixel_on_o),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  fbde_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .opcode_i (opcode_i),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .arg_x_i  (arg_x_i),
    .arg_y_i  (arg_y_i),
    .ink_i    (ink_i),
    .sts_o    (sts)
  );

endmodule

### hdl/fbde_checker.sv
// Port-level checks for the draw engine, attached to the top level by bind.
// No dependencies.
module fbde_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic pixel_on_o
);

  // A stalled result stays presented unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_on_o))
    else $error("result changed while stalled");

  // The engine is busy in the cycle after it takes a command.
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // A new result only comes from a command that was being worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

endmodule

bind mono_framebuffer_draw_engine_top fbde_checker u_fbde_checker (.*);

### bench/tb_mono_framebuffer_draw_engine_top.sv
// Self-checking testbench for mono_framebuffer_draw_engine_top.
// Depends on fbde_pkg; it keeps its own copy of the frame store and
// predicts each pixel_on result, while both channels idle and stall at random.
`timescale 1ns / 100ps

module tb_mono_framebuffer_draw_engine_top;
  import fbde_pkg::*;

  localparam int unsigned NUM_RANDOM = 800;
  localparam longint unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam logic [3:0] OP_UNUSED = 4'd15;

  typedef struct {
    logic [3:0]         op;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic [1:0]         ink;
    bit                 typed;  // the expected bit is given in the row
    bit                 pix;
  } draw_cmd_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [3:0]         opcode_i;
  logic signed [15:0] pos_x_i;
  logic signed [15:0] pos_y_i;
  logic signed [15:0] arg_x_i;
  logic signed [15:0] arg_y_i;
  logic [1:0]         ink_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               pixel_on_o;

  mono_framebuffer_draw_engine_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .arg_x_i     (arg_x_i),
    .arg_y_i     (arg_y_i),
    .ink_i       (ink_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_on_o  (pixel_on_o)
  );

  // The clock toggles every 10 ns for a 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Shadow copy of the frame store, updated as each command transfer lands.
  logic [7:0] shadow_fb [STORE_BYTES];
  bit         pixel_queue[$];
  int unsigned mismatch_count;
  int unsigned accepted_cmds;
  int unsigned checked_results;
  int unsigned reads_seen;
  int unsigned reads_lit;
  longint unsigned cycle_count;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH @%0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Coordinates that land on the screen are wrapped to 16 bits first.
  function automatic int wrap16(input int v);
    return int'($signed(v[15:0]));
  endfunction

  function automatic void shadow_plot(input int x, input int y, input logic [1:0] ink);
    int          wx;
    int          wy;
    int unsigned idx;
    logic [7:0]  mask;
    wx = wrap16(x);
    wy = wrap16(y);
    if (wx < 0 || wy < 0 || wx >= SCREEN_WIDTH || wy >= SCREEN_HEIGHT) return;
    idx  = wx + (wy / 8) * SCREEN_WIDTH;
    mask = 8'h01 << (wy & 7);
    case (ink)
      INK_WHITE:  shadow_fb[idx] = shadow_fb[idx] | mask;
      INK_BLACK:  shadow_fb[idx] = shadow_fb[idx] & ~mask;
      INK_INVERT: shadow_fb[idx] = shadow_fb[idx] ^ mask;
      default: ;
    endcase
  endfunction

  function automatic bit shadow_pixel(input int x, input int y);
    if (x < 0 || y < 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return 1'b0;
    return shadow_fb[x + (y / 8) * SCREEN_WIDTH][y & 7];
  endfunction

  function automatic void shadow_span(input int x, input int y, input int len,
                                      input bit vert, input logic [1:0] ink);
    for (int i = 0; i < len; i++) begin
      if (vert) shadow_plot(x, y + i, ink);
      else      shadow_plot(x + i, y, ink);
    end
  endfunction

  // Bresenham walk with inclusive endpoints; differences need 17 bits.
  function automatic void shadow_line(input int x0, input int y0, input int x1,
                                      input int y1, input logic [1:0] ink);
    int dx;
    int dy;
    int sx;
    int sy;
    int err;
    int e2;
    dx  = (x1 >= x0) ? x1 - x0 : x0 - x1;
    dy  = -((y1 >= y0) ? y1 - y0 : y0 - y1);
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    forever begin
      shadow_plot(x0, y0, ink);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x0  += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        y0  += sy;
      end
    end
  endfunction

  // Filled rectangle: the offset from the corner is taken modulo 2^16.
  function automatic void shadow_fill_rect(input int x0, input int y0, input int w,
                                           input int h, input logic [1:0] ink);
    logic [15:0] j;
    logic [15:0] i;
    if (w <= 0 || h <= 0) return;
    for (int y = 0; y < SCREEN_HEIGHT; y++) begin
      j = 16'(y - y0);
      if (int'(j) >= h) continue;
      for (int x = 0; x < SCREEN_WIDTH; x++) begin
        i = 16'(x - x0);
        if (int'(i) < w) shadow_plot(x, y, ink);
      end
    end
  endfunction

  // Midpoint circle, eight octant points per step; overlaps plot twice.
  function automatic void shadow_circle(input int cx, input int cy, input int r,
                                        input logic [1:0] ink);
    int x;
    int y;
    int err;
    if (r <= 0) begin
      shadow_plot(cx, cy, ink);
      return;
    end
    x   = r;
    y   = 0;
    err = 1 - r;
    while (x >= y) begin
      shadow_plot(cx + x, cy + y, ink);
      shadow_plot(cx + y, cy + x, ink);
      shadow_plot(cx - y, cy + x, ink);
      shadow_plot(cx - x, cy + y, ink);
      shadow_plot(cx - x, cy - y, ink);
      shadow_plot(cx - y, cy - x, ink);
      shadow_plot(cx + y, cy - x, ink);
      shadow_plot(cx + x, cy - y, ink);
      y++;
      if (err < 0) begin
        err += 2 * y + 1;
      end else begin
        x--;
        err += 2 * (y - x) + 1;
      end
    end
  endfunction

  function automatic void shadow_fill_circle(input int cx, input int cy, input int r,
                                             input logic [1:0] ink);
    longint rr;
    longint ddx;
    longint ddy;
    if (r < 0) return;
    rr = longint'(r) * r;
    for (int y = 0; y < SCREEN_HEIGHT; y++) begin
      ddy = wrap16(y - cy);
      if (ddy > r || ddy < -r) continue;
      for (int x = 0; x < SCREEN_WIDTH; x++) begin
        ddx = wrap16(x - cx);
        if (ddx > r || ddx < -r) continue;
        if (ddx * ddx + ddy * ddy <= rr) shadow_plot(x, y, ink);
      end
    end
  endfunction

  // Applies one command to the shadow store and returns the expected pixel_on.
  function automatic bit paint_command(input draw_cmd_t c);
    int px;
    int py;
    int ax;
    int ay;
    px = c.px;
    py = c.py;
    ax = c.ax;
    ay = c.ay;
    case (c.op)
      OP_CLEAR: begin
        foreach (shadow_fb[k]) shadow_fb[k] = (c.ink == INK_WHITE) ? 8'hFF : 8'h00;
      end
      OP_SET:      shadow_plot(px, py, c.ink);
      OP_READ:     return shadow_pixel(px, py);
      OP_HSPAN:    shadow_span(px, py, ax, 1'b0, c.ink);
      OP_VSPAN:    shadow_span(px, py, ay, 1'b1, c.ink);
      OP_LINE:     shadow_line(px, py, ax, ay, c.ink);
      OP_RECT: begin
        if (ax > 0 && ay > 0) begin
          shadow_span(px, py, ax, 1'b0, c.ink);
          shadow_span(px, py + ay - 1, ax, 1'b0, c.ink);
          shadow_span(px, py, ay, 1'b1, c.ink);
          shadow_span(px + ax - 1, py, ay, 1'b1, c.ink);
        end
      end
      OP_FILLRECT:   shadow_fill_rect(px, py, ax, ay, c.ink);
      OP_CIRCLE:     shadow_circle(px, py, ax, c.ink);
      OP_FILLCIRCLE: shadow_fill_circle(px, py, ax, c.ink);
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Directed commands. Rows with a typed expectation give the bit: reads where the
  // answer is obvious (after reset, after clears, and off-screen), else zero.
  localparam int NUM_DIRECTED = 27;
  draw_cmd_t directed_rows [NUM_DIRECTED] = '{
    '{OP_READ,       16'sd0,      16'sd0,      16'sd0,      16'sd0,     INK_WHITE,  1, 0},
    '{OP_READ,       16'sd127,    16'sd63,     -16'sd1,     -16'sd1,    INK_WHITE,  1, 0},
    '{OP_CLEAR,      16'sd0,      16'sd0,      16'sd0,      16'sd0,     INK_WHITE,  1, 0},
    '{OP_READ,       16'sd5,      16'sd5,      16'sd0,      16'sd0,     INK_WHITE,  1, 1},
    '{OP_SET,        16'sd127,    16'sd63,     16'sd0,      16'sd0,     INK_BLACK,  1, 0},
    '{OP_READ,       16'sd127,    16'sd63,     16'sd0,      16'sd0,     INK_WHITE,  1, 0},
    '{OP_READ,       -16'sd1,     16'sd0,      16'sd0,      16'sd0,     INK_WHITE,  1, 0},
    '{OP_READ,       16'sd32767,  -16'sd32768, 16'sd0,      16'sd0,     INK_INVERT, 1, 0},
    '{OP_CLEAR,      16'sd0,      16'sd0,      16'sd0,      16'sd0,     INK_INVERT, 1, 0},
    '{OP_READ,       16'sd64,     16'sd32,     16'sd0,      16'sd0,     INK_WHITE,  1, 0},
    '{OP_CLEAR,      16'sd0,      16'sd0,      16'sd0,      16'sd0,     2'd3,       1, 0},
    '{OP_SET,        16'sd3,      16'sd3,      16'sd0,      16'sd0,     2'd3,       1, 0},
    '{OP_SET,        16'sd3,      16'sd4,      16'sd0,      16'sd0,     INK_INVERT, 1, 0},
    '{OP_HSPAN,      16'sd0,      16'sd8,      16'sd0,      16'sd0,     INK_WHITE,  1, 0},
    '{OP_HSPAN,      -16'sd32768, 16'sd9,      16'sd32767,  16'sd0,     INK_WHITE,  1, 0},
    '{OP_VSPAN,      16'sd10,     -16'sd32768, 16'sd0,      16'sd32767, INK_INVERT, 1, 0},
    '{OP_VSPAN,      16'sd11,     16'sd0,      16'sd0,      -16'sd32768, INK_WHITE, 1, 0},
    '{OP_LINE,       -16'sd32768, 16'sd10,     16'sd32767,  16'sd20,    INK_INVERT, 1, 0},
    '{OP_LINE,       16'sd40,     16'sd40,     16'sd40,     16'sd40,    INK_WHITE,  0, 0},
    '{OP_RECT,       16'sd20,     16'sd20,     16'sd30,     16'sd10,    INK_INVERT, 0, 0},
    '{OP_RECT,       16'sd20,     16'sd20,     16'sd0,      16'sd10,    INK_WHITE,  1, 0},
    '{OP_FILLRECT,   -16'sd4,     16'sd50,     16'sd40,     16'sd20,    INK_INVERT, 1, 0},
    '{OP_CIRCLE,     16'sd60,     16'sd30,     -16'sd32768, 16'sd0,     INK_INVERT, 1, 0},
    '{OP_CIRCLE,     16'sd60,     16'sd30,     16'sd1,      16'sd0,     INK_INVERT, 1, 0},
    '{OP_FILLCIRCLE, 16'sd90,     16'sd30,     -16'sd1,     16'sd0,     INK_WHITE,  1, 0},
    '{OP_FILLCIRCLE, 16'sd0,      16'sd0,      16'sd32767,  16'sd0,     INK_INVERT, 1, 0},
    '{OP_UNUSED,     -16'sd1,     -16'sd1,     -16'sd1,     -16'sd1,    INK_BLACK,  1, 0}
  };

  function automatic logic signed [15:0] near_coord();
    return 16'($urandom_range(0, 159)) - 16'sd16;
  endfunction

  function automatic logic signed [15:0] any_coord();
    return 16'($urandom);
  endfunction

  // Random commands stay mostly near the screen so shapes stay cheap; a few
  // filled shapes and far coordinates reach the wrap and clipping logic.
  function automatic draw_cmd_t random_command();
    draw_cmd_t c;
    int        sel;
    int        delta;
    int        end_x;
    int        end_y;
    sel   = $urandom_range(0, 99);
    c.px  = near_coord();
    c.py  = near_coord();
    c.ax  = any_coord();
    c.ay  = any_coord();
    c.ink = 2'($urandom_range(0, 3));
    c.typed = 1'b0;
    c.pix   = 1'b0;
    if (sel < 1) begin
      c.op = OP_CLEAR;
    end else if (sel < 3) begin
      c.op = ($urandom_range(0, 1) != 0) ? OP_FILLRECT : OP_FILLCIRCLE;
      if (c.op == OP_FILLRECT || $urandom_range(0, 2) != 0) begin
        c.ax = 16'($urandom_range(0, 90)) - 16'sd3;
        if (c.op == OP_FILLRECT) c.ay = 16'($urandom_range(0, 70)) - 16'sd3;
      end
    end else if (sel < 6) begin
      c.op = 4'($urandom_range(10, 15));
    end else if (sel < 30) begin
      c.op = OP_READ;
      if ($urandom_range(0, 4) == 0) c.px = any_coord();
      if ($urandom_range(0, 4) == 0) c.py = any_coord();
    end else if (sel < 48) begin
      c.op = OP_SET;
      if ($urandom_range(0, 4) == 0) c.px = any_coord();
      if ($urandom_range(0, 4) == 0) c.py = any_coord();
    end else if (sel < 58) begin
      c.op = OP_HSPAN;
      c.ax = 16'($urandom_range(0, 150)) - 16'sd4;
    end else if (sel < 68) begin
      c.op = OP_VSPAN;
      c.ay = 16'($urandom_range(0, 90)) - 16'sd4;
    end else if (sel < 82) begin
      c.op = OP_LINE;
      if ($urandom_range(0, 9) == 0) begin
        c.px  = any_coord();
        c.py  = any_coord();
        delta = int'($urandom_range(0, 80)) - 40;
        end_x = int'(c.px) + delta;
        if (end_x > 32767 || end_x < -32768) end_x = int'(c.px) - delta;
        delta = int'($urandom_range(0, 80)) - 40;
        end_y = int'(c.py) + delta;
        if (end_y > 32767 || end_y < -32768) end_y = int'(c.py) - delta;
        c.ax = 16'(end_x);
        c.ay = 16'(end_y);
      end else begin
        c.ax = near_coord();
        c.ay = near_coord();
      end
    end else if (sel < 90) begin
      c.op = OP_RECT;
      c.ax = 16'($urandom_range(0, 80)) - 16'sd3;
      c.ay = 16'($urandom_range(0, 60)) - 16'sd3;
    end else begin
      c.op = OP_CIRCLE;
      c.ax = ($urandom_range(0, 19) == 0) ? (any_coord() | 16'sh8000)
                                          : 16'($urandom_range(0, 50)) - 16'sd3;
    end
    return c;
  endfunction

  // Command sender: bursts of random length separated by random gaps, with
  // some bursts running back to back. An item is held until it transfers.
  initial begin
    draw_cmd_t   cur;
    draw_cmd_t   nxt;
    int unsigned issued;
    int unsigned burst_left;
    int unsigned gap_left;
    bit          offering;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_CLEAR;
    pos_x_i     = '0;
    pos_y_i     = '0;
    arg_x_i     = '0;
    arg_y_i     = '0;
    ink_i       = INK_WHITE;
    issued      = 0;
    burst_left  = 0;
    gap_left    = 0;
    offering    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (issued < NUM_DIRECTED + NUM_RANDOM || offering) begin
      @(posedge clk_i);
      if (offering && in_valid_i && !in_stall_o) begin
        if (cur.typed) begin
          void'(paint_command(cur));
          pixel_queue.push_back(cur.pix);
        end else begin
          pixel_queue.push_back(paint_command(cur));
        end
        if (cur.op == OP_READ) reads_seen++;
        accepted_cmds++;
        offering = 1'b0;
      end
      if (!offering && issued < NUM_DIRECTED + NUM_RANDOM) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0 && burst_left == 0) begin
          gap_left--;
        end else begin
          nxt = (issued < NUM_DIRECTED) ? directed_rows[issued] : random_command();
          cur = nxt;
          issued++;
          offering = 1'b1;
          if (burst_left > 0) burst_left--;
        end
      end
      in_valid_i <= offering;
      if (offering) begin
        opcode_i <= cur.op;
        pos_x_i  <= cur.px;
        pos_y_i  <= cur.py;
        arg_x_i  <= cur.ax;
        arg_y_i  <= cur.ay;
        ink_i    <= cur.ink;
      end
    end
    wait (pixel_queue.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Ran %0d directed and %0d random commands covering all ten shapes and ink",
             NUM_DIRECTED, NUM_RANDOM);
    $display("codes; %0d results checked, %0d of %0d reads found a lit pixel.",
             checked_results, reads_lit, reads_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result receiver: stalls in a randomly redrawn pattern (never, light or heavy),
  // and once holds off for a long stretch so the engine backs up into its input.
  int unsigned hold_left;
  bit          hold_done;
  int unsigned stall_mode;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
      stall_mode  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pixel_queue.size() == 0) begin
          report_mismatch("result with nothing pending, pixel_on", pixel_on_o, 0);
        end else begin
          if (pixel_on_o !== pixel_queue[0]) begin
            report_mismatch("pixel_on", pixel_on_o, pixel_queue[0]);
          end
          if (pixel_queue[0]) reads_lit++;
          void'(pixel_queue.pop_front());
          checked_results++;
        end
      end
      if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
      if (!hold_done && accepted_cmds >= 300) begin
        hold_done   <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 9) < 3);
          default: out_stall_i <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding.", pixel_queue.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    cycle_count     = 0;
    mismatch_count  = 0;
    accepted_cmds   = 0;
    checked_results = 0;
    reads_seen      = 0;
    reads_lit       = 0;
    foreach (shadow_fb[k]) shadow_fb[k] = 8'h00;
  end

endmodule

### filelist.f
hdl/fbde_pkg.sv
hdl/fbde_ram.sv
hdl/fbde_ctrl.sv
hdl/fbde_dpath.sv
hdl/mono_framebuffer_draw_engine_top.sv
hdl/fbde_checker.sv
bench/tb_mono_framebuffer_draw_engine_top.sv
